[src/lss_pkg.sv]
// shared types and constants for the lidar sector speed limiter
`default_nettype none
package lss_pkg;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);

  localparam logic [1:0] ACT_POINT = 2'd0;
  localparam logic [1:0] ACT_SCAN  = 2'd1;
  localparam logic [1:0] ACT_TICK  = 2'd2;

  localparam logic [1:0] OP_POINT = 2'd0;
  localparam logic [1:0] OP_SCAN  = 2'd1;
  localparam logic [1:0] OP_TICK  = 2'd2;

  localparam logic [2:0] ST_OPEN     = 3'd0;
  localparam logic [2:0] ST_CORRIDOR = 3'd1;
  localparam logic [2:0] ST_CORNER   = 3'd2;
  localparam logic [2:0] ST_DENSE    = 3'd3;
  localparam logic [2:0] ST_UNKNOWN  = 3'd4;

  localparam logic [2:0] SEC_FRONT = 3'd0;
  localparam logic [2:0] SEC_FL    = 3'd1;
  localparam logic [2:0] SEC_FR    = 3'd2;
  localparam logic [2:0] SEC_LEFT  = 3'd3;
  localparam logic [2:0] SEC_RIGHT = 3'd4;
  localparam int         NUM_SEC   = 5;

  localparam logic [16:0] BOUND_FRONT = 17'd4681;
  localparam logic [16:0] BOUND_DIAG  = 17'd14043;
  localparam logic [16:0] BOUND_SIDE  = 17'd23405;

  localparam logic [15:0] NO_RETURN = 16'hFFFF;

  localparam logic [2:0] REG_CORRIDOR = 3'd0;
  localparam logic [2:0] REG_CORNER   = 3'd1;
  localparam logic [2:0] REG_DANGER   = 3'd2;
  localparam logic [2:0] REG_MIN_RNG  = 3'd3;
  localparam logic [2:0] REG_MAX_RNG  = 3'd4;
  localparam logic [2:0] REG_CONFIRM  = 3'd5;
  localparam logic [2:0] REG_STEP     = 3'd6;
  localparam logic [2:0] REG_LIMITS   = 3'd7;

  typedef struct packed {
    logic [15:0] corridor_thr;
    logic [15:0] corner_thr;
    logic [15:0] danger_thr;
    logic [15:0] min_range;
    logic [15:0] max_range;
    logic [7:0]  confirm_count;
    logic [11:0] step_per_tick;
    logic [59:0] limit_table;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  op;
    logic [2:0]  sector;
    logic [15:0] range_mm;
  } qitem_t;

endpackage
`default_nettype wire

[src/lidar_sector_speed_limiter.sv]
// lidar sector speed limiter top level
// path: an accepted tick is written into the queue, popped by the back end and, if it emits,
// registered onto out_tvalid; it waits behind transactions queued ahead of it and out_tready stalls
// throughput: one input transaction per cycle while the queue is not full (in_tready high)
// a four-entry queue lets the front keep accepting while a result waits on out_tready
// reset: synchronous active-low rst_n restores registers, minima, state and level defaults
`default_nettype none
module lidar_sector_speed_limiter #(
  parameter int WATCHDOG_TICKS = 3
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [31:0] in_tdata,   // range_mm, angle
  input  wire logic [2:0]  in_tuser,   // action, point_valid
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [15:0]      out_tdata,  // limit_level, env_state, zero pad
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_addr,
  input  wire logic [59:0] cfg_wdata
);
  import lss_pkg::*;

  cfg_t        cfg_r;
  qitem_t      f_item;
  logic        f_keep;
  logic        q_full;
  qitem_t      q_head;
  logic        q_valid;
  logic        q_pop;
  logic [11:0] o_level;
  logic [2:0]  o_state;
  logic        in_acc;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.corridor_thr  <= 16'd1200;
      cfg_r.corner_thr    <= 16'd1000;
      cfg_r.danger_thr    <= 16'd450;
      cfg_r.min_range     <= 16'd100;
      cfg_r.max_range     <= 16'd6000;
      cfg_r.confirm_count <= 8'd3;
      cfg_r.step_per_tick <= 12'd64;
      cfg_r.limit_table   <= 60'h780_320_500_6E0_C80;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_CORRIDOR: cfg_r.corridor_thr  <= cfg_wdata[15:0];
        REG_CORNER:   cfg_r.corner_thr    <= cfg_wdata[15:0];
        REG_DANGER:   cfg_r.danger_thr    <= cfg_wdata[15:0];
        REG_MIN_RNG:  cfg_r.min_range     <= cfg_wdata[15:0];
        REG_MAX_RNG:  cfg_r.max_range     <= cfg_wdata[15:0];
        REG_CONFIRM:  cfg_r.confirm_count <= cfg_wdata[7:0];
        REG_STEP:     cfg_r.step_per_tick <= cfg_wdata[11:0];
        REG_LIMITS:   cfg_r.limit_table   <= cfg_wdata;
        default:      cfg_r.limit_table   <= cfg_r.limit_table;
      endcase
    end
  end

  assign in_tready = !q_full;
  assign in_acc    = in_tvalid && in_tready;

  lss_front u_front (
    .action      (in_tuser[1:0]),
    .range_mm    (in_tdata[15:0]),
    .angle       (in_tdata[31:16]),
    .point_valid (in_tuser[2]),
    .cfg         (cfg_r),
    .item        (f_item),
    .item_keep   (f_keep)
  );

  lss_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_acc && f_keep),
    .push_item (f_item),
    .full      (q_full),
    .pop       (q_pop),
    .head      (q_head),
    .not_empty (q_valid)
  );

  lss_back #(
    .WATCHDOG_TICKS (WATCHDOG_TICKS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_valid   (q_valid),
    .q_item    (q_head),
    .q_pop     (q_pop),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_level (o_level),
    .out_state (o_state)
  );

  assign out_tdata = {1'b0, o_state, o_level};

endmodule
`default_nettype wire

[src/lss_front.sv]
// front end: screens points by range and rear angle, bins them into sectors and passes scan and tick
`default_nettype none
module lss_front (
  input  wire logic [1:0]     action,
  input  wire logic [15:0]    range_mm,
  input  wire logic [15:0]    angle,
  input  wire logic           point_valid,
  input  wire lss_pkg::cfg_t  cfg,
  output lss_pkg::qitem_t     item,
  output logic                item_keep
);
  import lss_pkg::*;

  logic signed [16:0] ang_s;
  logic [16:0]        mag;
  logic               left;
  logic               in_range;
  logic [2:0]         sec;
  logic               rear;

  always_comb begin
    ang_s    = 17'(signed'(angle));
    mag      = ang_s[16] ? 17'(-ang_s) : 17'(ang_s);
    left     = !ang_s[16] && (ang_s != 17'sd0);
    in_range = point_valid && (range_mm >= cfg.min_range) && (range_mm <= cfg.max_range);
    rear     = 1'b0;
    if (mag <= BOUND_FRONT) begin
      sec = SEC_FRONT;
    end else if (mag <= BOUND_DIAG) begin
      sec = left ? SEC_FL : SEC_FR;
    end else if (mag <= BOUND_SIDE) begin
      sec = left ? SEC_LEFT : SEC_RIGHT;
    end else begin
      sec  = SEC_FRONT;
      rear = 1'b1;
    end

    item.sector   = sec;
    item.range_mm = range_mm;
    item.op       = OP_POINT;
    item_keep     = 1'b0;
    unique case (action)
      ACT_POINT: begin
        item.op   = OP_POINT;
        item_keep = in_range && !rear;
      end
      ACT_SCAN: begin
        item.op   = OP_SCAN;
        item_keep = 1'b1;
      end
      ACT_TICK: begin
        item.op   = OP_TICK;
        item_keep = 1'b1;
      end
      default: begin
        item.op   = OP_POINT;
        item_keep = 1'b0;
      end
    endcase
  end

endmodule
`default_nettype wire

[src/lss_queue.sv]
// small register fifo between front and back
`default_nettype none
module lss_queue (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire lss_pkg::qitem_t  push_item,
  output logic                  full,
  input  wire logic             pop,
  output lss_pkg::qitem_t       head,
  output logic                  not_empty
);
  import lss_pkg::*;

  qitem_t             mem_r [QDEPTH];
  logic [QPTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [QPTR_W:0]    count_r, count_nxt;

  assign full      = (count_r == (QPTR_W+1)'(QDEPTH));
  assign not_empty = (count_r != '0);
  assign head      = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule
`default_nettype wire

[src/lss_back.sv]
// back end: sector minima, scan classification, watchdog, slew and result register
`default_nettype none
module lss_back #(
  parameter int WATCHDOG_TICKS = 3
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire lss_pkg::cfg_t    cfg,
  input  wire logic             q_valid,
  input  wire lss_pkg::qitem_t  q_item,
  output logic                  q_pop,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output logic [11:0]           out_level,
  output logic [2:0]            out_state
);
  import lss_pkg::*;

  localparam logic [2:0] WD_LIMIT = 3'(WATCHDOG_TICKS);

  logic [15:0] min_r [NUM_SEC];
  logic [15:0] min_nxt [NUM_SEC];
  logic [2:0]  cur_r, cur_nxt;
  logic [2:0]  cand_r, cand_nxt;
  logic [7:0]  streak_r, streak_nxt;
  logic [11:0] level_r, level_nxt;
  logic        pub_r, pub_nxt;
  logic        seen_r, seen_nxt;
  logic [2:0]  ticks_r, ticks_nxt;
  logic        ov_r, ov_nxt;
  logic [11:0] olvl_r;
  logic [2:0]  ost_r;

  logic        do_point, do_scan, do_tick;
  logic [2:0]  cls;
  logic [7:0]  streak_inc;
  logic [2:0]  tick_state;
  logic [11:0] target, diff, stp;
  logic        emit;

  assign q_pop     = q_valid && (!ov_r || out_ready);
  assign do_point  = q_pop && (q_item.op == OP_POINT);
  assign do_scan   = q_pop && (q_item.op == OP_SCAN);
  assign do_tick   = q_pop && (q_item.op == OP_TICK);
  assign out_valid = ov_r;
  assign out_level = olvl_r;
  assign out_state = ost_r;

  always_comb begin
    if ((min_r[SEC_FRONT] < cfg.danger_thr) &&
        ((min_r[SEC_FL] < cfg.danger_thr) || (min_r[SEC_FR] < cfg.danger_thr) ||
         (min_r[SEC_LEFT] < cfg.danger_thr) || (min_r[SEC_RIGHT] < cfg.danger_thr))) begin
      cls = ST_DENSE;
    end else if (min_r[SEC_FRONT] < cfg.corner_thr) begin
      cls = ST_CORNER;
    end else if ((min_r[SEC_LEFT] < cfg.corridor_thr) &&
                 (min_r[SEC_RIGHT] < cfg.corridor_thr)) begin
      cls = ST_CORRIDOR;
    end else begin
      cls = ST_OPEN;
    end

    streak_inc = (streak_r == 8'hFF) ? streak_r : streak_r + 8'd1;

    tick_state = (!seen_r || (ticks_r >= WD_LIMIT)) ? ST_UNKNOWN : cur_r;
    unique case (tick_state)
      ST_OPEN:     target = cfg.limit_table[11:0];
      ST_CORRIDOR: target = cfg.limit_table[23:12];
      ST_CORNER:   target = cfg.limit_table[35:24];
      ST_DENSE:    target = cfg.limit_table[47:36];
      default:     target = cfg.limit_table[59:48];
    endcase
    diff = (target > level_r) ? target - level_r : level_r - target;
    stp  = (diff < cfg.step_per_tick) ? diff : cfg.step_per_tick;

    for (int i = 0; i < NUM_SEC; i++) begin
      min_nxt[i] = min_r[i];
    end
    cur_nxt    = cur_r;
    cand_nxt   = cand_r;
    streak_nxt = streak_r;
    level_nxt  = level_r;
    pub_nxt    = pub_r;
    seen_nxt   = seen_r;
    ticks_nxt  = ticks_r;
    emit       = 1'b0;

    if (do_point) begin
      if (q_item.range_mm < min_r[q_item.sector]) begin
        min_nxt[q_item.sector] = q_item.range_mm;
      end
    end

    if (do_scan) begin
      if (cls == cur_r) begin
        streak_nxt = '0;
      end else if (cls != cand_r) begin
        cand_nxt   = cls;
        streak_nxt = 8'd1;
      end else if (streak_inc >= cfg.confirm_count) begin
        cur_nxt    = cls;
        streak_nxt = '0;
      end else begin
        streak_nxt = streak_inc;
      end
      for (int i = 0; i < NUM_SEC; i++) begin
        min_nxt[i] = NO_RETURN;
      end
      seen_nxt  = 1'b1;
      ticks_nxt = '0;
    end

    if (do_tick) begin
      cur_nxt   = tick_state;
      ticks_nxt = (ticks_r == 3'd7) ? ticks_r : ticks_r + 3'd1;
      level_nxt = (target > level_r) ? level_r + stp : level_r - stp;
      emit      = (level_nxt != level_r) || !pub_r;
      if (emit) begin
        pub_nxt = 1'b1;
      end
    end

    if (emit) begin
      ov_nxt = 1'b1;
    end else if (out_ready) begin
      ov_nxt = 1'b0;
    end else begin
      ov_nxt = ov_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_SEC; i++) begin
        min_r[i] <= NO_RETURN;
      end
      cur_r    <= ST_UNKNOWN;
      cand_r   <= ST_UNKNOWN;
      streak_r <= '0;
      level_r  <= 12'd1920;
      pub_r    <= 1'b0;
      seen_r   <= 1'b0;
      ticks_r  <= '0;
      ov_r     <= 1'b0;
    end else begin
      for (int i = 0; i < NUM_SEC; i++) begin
        min_r[i] <= min_nxt[i];
      end
      cur_r    <= cur_nxt;
      cand_r   <= cand_nxt;
      streak_r <= streak_nxt;
      level_r  <= level_nxt;
      pub_r    <= pub_nxt;
      seen_r   <= seen_nxt;
      ticks_r  <= ticks_nxt;
      ov_r     <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      olvl_r <= level_nxt;
      ost_r  <= cur_nxt;
    end
  end

  a_first_tick_emits: assert property (@(posedge clk) disable iff (!rst_n)
    (do_tick && !pub_r) |=> (ov_r && pub_r))
    else $error("first tick did not produce a result");

  a_scan_resets_watchdog: assert property (@(posedge clk) disable iff (!rst_n)
    do_scan |=> (seen_r && (ticks_r == 3'd0) && (min_r[SEC_FRONT] == NO_RETURN)))
    else $error("end of scan did not clear watchdog or minima");

  a_watchdog_forces_unknown: assert property (@(posedge clk) disable iff (!rst_n)
    (do_tick && !seen_r) |=> (cur_r == ST_UNKNOWN))
    else $error("watchdog did not force unknown state");

  a_state_range: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r |-> (ost_r <= ST_UNKNOWN))
    else $error("result state out of range");

endmodule
`default_nettype wire
